/* sv/shsp_pkg.sv */
package shsp_pkg;

    localparam int unsigned FIXED_LEN = 2 + 32 + 1;
    localparam int unsigned POS_W = 6;
    localparam logic [15:0] KEY_SHARE_TYPE = 16'h0033;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W = 2;
    localparam int unsigned QCNT_W = 3;

    typedef enum logic [2:0] {
        PH_HEAD    = 3'd0,
        PH_SID     = 3'd1,
        PH_SUITE   = 3'd2,
        PH_COMP    = 3'd3,
        PH_EXTLEN  = 3'd4,
        PH_EXTHDR  = 3'd5,
        PH_EXTSKIP = 3'd6,
        PH_KSHARE  = 3'd7
    } shsp_phase_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TOO_SHORT   = 3'd1,
        ST_TRUNCATED   = 3'd2,
        ST_NO_EXT      = 3'd3,
        ST_EXT_OVERFLOW = 3'd4,
        ST_KEY_MISSING = 3'd5
    } shsp_status_t;

    localparam logic KIND_KEY = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  key_byte;
        logic [15:0] cipher_suite;
        logic [2:0]  status;
        logic        final_flag;
    } shsp_result_t;

    typedef struct packed {
        logic         key_push;
        logic         verdict_push;
        shsp_result_t key_res;
        shsp_result_t verdict_res;
    } shsp_push_t;

endpackage

/* sv/shsp_parser.sv */
module shsp_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          body_byte,
    input  logic                end_of_body,
    output shsp_pkg::shsp_push_t push
);
    import shsp_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    shsp_phase_t      phase_reg, phase_next;
    logic [15:0]      skip_reg, skip_next;
    logic [15:0]      suite_reg, suite_next;
    logic [15:0]      ext_end_reg, ext_end_next;
    logic [31:0]      hdr_reg, hdr_next;
    logic [15:0]      key_left_reg, key_left_next;
    logic             key_seen_reg, key_seen_next;
    logic             scan_done_reg, scan_done_next;

    logic [15:0]      ee_dec;
    logic [15:0]      skip_dec;
    logic [15:0]      kl_dec;
    logic [15:0]      kl_new;
    logic [31:0]      hdr_new;
    logic [15:0]      elen;
    logic             emit_key;
    shsp_status_t     verdict;

    always_comb
    begin
        ee_dec   = ((phase_reg >= PH_EXTHDR) && (ext_end_reg != 16'd0)) ?
                   ext_end_reg - 16'd1 : ext_end_reg;
        skip_dec = (skip_reg != 16'd0) ? skip_reg - 16'd1 : skip_reg;
        kl_dec   = (key_left_reg != 16'd0) ? key_left_reg - 16'd1 : key_left_reg;
        hdr_new  = {hdr_reg[23:0], body_byte};
        elen     = hdr_new[15:0];
        kl_new   = key_left_reg;
        emit_key = 1'b0;

        pos_next       = pos_reg;
        phase_next     = phase_reg;
        skip_next      = skip_reg;
        suite_next     = suite_reg;
        ext_end_next   = ee_dec;
        hdr_next       = hdr_reg;
        key_left_next  = key_left_reg;
        key_seen_next  = key_seen_reg;
        scan_done_next = scan_done_reg;

        if (!((phase_reg >= PH_EXTHDR) && scan_done_reg))
        begin
            case (phase_reg)
                PH_HEAD:
                begin
                    if (pos_reg == POS_W'(FIXED_LEN - 1))
                    begin
                        skip_next  = {8'h00, body_byte};
                        pos_next   = '0;
                        phase_next = (body_byte != 8'h00) ? PH_SID : PH_SUITE;
                    end
                    else
                    begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                end
                PH_SID, PH_COMP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0)
                    begin
                        phase_next = (phase_reg == PH_SID) ? PH_SUITE : PH_EXTLEN;
                        pos_next   = '0;
                    end
                end
                PH_SUITE:
                begin
                    if (pos_reg == POS_W'(0))
                    begin
                        suite_next = {body_byte, 8'h00};
                        pos_next   = POS_W'(1);
                    end
                    else if (pos_reg == POS_W'(1))
                    begin
                        suite_next = {suite_reg[15:8], body_byte};
                        pos_next   = POS_W'(2);
                    end
                    else
                    begin
                        skip_next  = {8'h00, body_byte};
                        pos_next   = '0;
                        phase_next = (body_byte != 8'h00) ? PH_COMP : PH_EXTLEN;
                    end
                end
                PH_EXTLEN:
                begin
                    if (pos_reg == POS_W'(0))
                    begin
                        ext_end_next = {body_byte, 8'h00};
                        pos_next     = POS_W'(1);
                    end
                    else
                    begin
                        ext_end_next = {ext_end_reg[15:8], body_byte};
                        phase_next   = PH_EXTHDR;
                        pos_next     = '0;
                        if ({ext_end_reg[15:8], body_byte} < 16'd4)
                            scan_done_next = 1'b1;
                    end
                end
                PH_EXTHDR:
                begin
                    hdr_next = hdr_new;
                    pos_next = pos_reg + POS_W'(1);
                    if (pos_reg >= POS_W'(3))
                    begin
                        pos_next = '0;
                        if (elen > ee_dec)
                        begin
                            scan_done_next = 1'b1;
                        end
                        else if ((hdr_new[31:16] == KEY_SHARE_TYPE) && (elen >= 16'd4))
                        begin
                            skip_next  = elen;
                            phase_next = PH_KSHARE;
                        end
                        else if (elen == 16'd0)
                        begin
                            if (ee_dec < 16'd4)
                                scan_done_next = 1'b1;
                        end
                        else
                        begin
                            skip_next  = elen;
                            phase_next = PH_EXTSKIP;
                        end
                    end
                end
                PH_EXTSKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0)
                    begin
                        phase_next = PH_EXTHDR;
                        pos_next   = '0;
                        if (ee_dec < 16'd4)
                            scan_done_next = 1'b1;
                    end
                end
                PH_KSHARE:
                begin
                    if (pos_reg < POS_W'(4))
                    begin
                        if (pos_reg == POS_W'(2))
                            kl_new = {body_byte, 8'h00};
                        else if (pos_reg == POS_W'(3))
                            kl_new = {key_left_reg[15:8], body_byte};
                        key_left_next = kl_new;
                        pos_next      = pos_reg + POS_W'(1);
                        if (pos_reg == POS_W'(3))
                        begin
                            if ((kl_new == 16'd0) ||
                                ({1'b0, skip_reg} < (17'd4 + {1'b0, kl_new})))
                            begin
                                key_left_next  = 16'd0;
                                scan_done_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        emit_key      = 1'b1;
                        key_seen_next = 1'b1;
                        key_left_next = kl_dec;
                        if (kl_dec == 16'd0)
                            scan_done_next = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        if (phase_next == PH_HEAD)
            verdict = ST_TOO_SHORT;
        else if ((phase_next == PH_SID) || (phase_next == PH_SUITE))
            verdict = ST_TRUNCATED;
        else if ((phase_next == PH_COMP) || (phase_next == PH_EXTLEN))
            verdict = ST_NO_EXT;
        else if (ext_end_next != 16'd0)
            verdict = ST_EXT_OVERFLOW;
        else if (key_seen_next)
            verdict = ST_OK;
        else
            verdict = ST_KEY_MISSING;

        push.key_push                 = take && emit_key;
        push.key_res.result_kind      = KIND_KEY;
        push.key_res.key_byte         = body_byte;
        push.key_res.cipher_suite     = 16'h0000;
        push.key_res.status           = ST_OK;
        push.key_res.final_flag       = 1'b0;
        push.verdict_push             = take && end_of_body;
        push.verdict_res.result_kind  = KIND_VERDICT;
        push.verdict_res.key_byte     = 8'h00;
        push.verdict_res.cipher_suite =
            ((verdict == ST_TOO_SHORT) || (verdict == ST_TRUNCATED)) ? 16'h0000 : suite_next;
        push.verdict_res.status       = verdict;
        push.verdict_res.final_flag   = 1'b1;

        if (end_of_body)
        begin
            pos_next       = '0;
            phase_next     = PH_HEAD;
            skip_next      = 16'd0;
            suite_next     = 16'd0;
            ext_end_next   = 16'd0;
            hdr_next       = 32'd0;
            key_left_next  = 16'd0;
            key_seen_next  = 1'b0;
            scan_done_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            phase_reg     <= PH_HEAD;
            skip_reg      <= 16'd0;
            suite_reg     <= 16'd0;
            ext_end_reg   <= 16'd0;
            hdr_reg       <= 32'd0;
            key_left_reg  <= 16'd0;
            key_seen_reg  <= 1'b0;
            scan_done_reg <= 1'b0;
        end
        else if (take)
        begin
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            skip_reg      <= skip_next;
            suite_reg     <= suite_next;
            ext_end_reg   <= ext_end_next;
            hdr_reg       <= hdr_next;
            key_left_reg  <= key_left_next;
            key_seen_reg  <= key_seen_next;
            scan_done_reg <= scan_done_next;
        end
    end

endmodule

/* sv/shsp_outq.sv */
module shsp_outq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  shsp_pkg::shsp_push_t   push,
    output logic                   room,
    output logic                   out_valid,
    input  logic                   out_ready,
    output shsp_pkg::shsp_result_t head
);
    import shsp_pkg::*;

    shsp_result_t      mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [QPTR_W-1:0] verdict_slot;
    logic              pop;
    logic [QCNT_W-1:0] n_push;

    always_comb
    begin
        pop          = out_valid && out_ready;
        n_push       = QCNT_W'(push.key_push) + QCNT_W'(push.verdict_push);
        verdict_slot = wr_ptr_reg + QPTR_W'(push.key_push);
        wr_ptr_next  = wr_ptr_reg + n_push[QPTR_W-1:0];
        rd_ptr_next  = rd_ptr_reg + QPTR_W'(pop);
        count_next   = count_reg + n_push - QCNT_W'(pop);
    end

    assign out_valid = (count_reg != '0);
    assign room      = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push.key_push)
            mem[wr_ptr_reg] <= push.key_res;
        if (push.verdict_push)
            mem[verdict_slot] <= push.verdict_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/server_hello_key_share_parser.sv */
// each result enters the output queue when its byte is taken, behind any earlier results
// throughput: one byte per cycle while in_ready is high; a key byte that is also the
// last byte gives two results, which leave the four-entry output queue one at a time
// in_ready drops while the output queue holds more than two results
// reset: asynchronous, clears the parse state to the fixed header phase and empties the queue
module server_hello_key_share_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  body_byte,
    input  logic        end_of_body,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [7:0]  key_byte,
    output logic [15:0] cipher_suite,
    output logic [2:0]  status,
    output logic        final_flag
);
    import shsp_pkg::*;

    shsp_push_t   push;
    shsp_result_t head;
    logic         room;
    logic         take;

    assign in_ready = room;
    assign take     = in_valid && room;

    shsp_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .body_byte   (body_byte),
        .end_of_body (end_of_body),
        .push        (push)
    );

    shsp_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign result_kind  = head.result_kind;
    assign key_byte     = head.key_byte;
    assign cipher_suite = head.cipher_suite;
    assign status       = head.status;
    assign final_flag   = head.final_flag;

    // stalled input means results are waiting
    a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty output queue");

    a_key_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (result_kind == KIND_KEY)) |->
        ((status == ST_OK) && (cipher_suite == 16'h0000) && !final_flag))
        else $error("key transaction carries verdict fields");

    a_verdict_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (result_kind == KIND_VERDICT)) |->
        ((key_byte == 8'h00) && final_flag && (status <= ST_KEY_MISSING)))
        else $error("malformed verdict transaction");

endmodule
